>>> rtl/pmtc_pkg.sv
package pmtc_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned DEBOUNCE_W  = 8;
  localparam int unsigned STROBE_W    = 4;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SAMPLE_W-1:0]   PAPER_THRESHOLD_RST = 12'd550;
  localparam logic [DEBOUNCE_W-1:0] PAPER_DEBOUNCE_RST  = 8'd100;
  localparam logic [STROBE_W-1:0]   STROBE_ON_RST       = 4'd5;
  localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST   = 16'd10;
  localparam logic [PHASE_W-1:0]    STEPS_PER_BURST_RST = 3'd4;

  // strobe frame bound: a frame ends once its off ticks plus the on-ticks setting exceed it
  localparam logic [STROBE_W:0]     STROBE_FRAME        = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAPER_THRESHOLD = 3'd0,
    CFG_PAPER_DEBOUNCE  = 3'd1,
    CFG_STROBE_ON_TICKS = 3'd2,
    CFG_STEP_INTERVAL   = 3'd3,
    CFG_STEPS_PER_BURST = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STROBE_OFF   = 2'd0,
    STROBE_ON    = 2'd1,
    STROBE_RESET = 2'd2
  } strobe_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] paper_sample;
    logic                heat_master_set;
    logic                heat_master_clear;
    logic                heat_run_set;
    logic                motor_master_set;
    logic                motor_master_clear;
    logic                motor_start;
  } in_item_t;

  typedef struct packed {
    logic               paper_present;
    logic [1:0]         strobe_state;
    logic               step_pulse;
    logic [PHASE_W-1:0] step_phase_out;
    logic               motor_busy;
    logic               heat_enabled;
    logic               motor_enabled;
  } out_item_t;

endpackage

>>> rtl/pmtc_in_if.sv
interface pmtc_in_if;
  logic               valid;
  logic               ready;
  pmtc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pmtc_out_if.sv
interface pmtc_out_if;
  logic                valid;
  logic                ready;
  pmtc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/print_head_motor_tick_controller.sv
// result: each input transfer's result is registered into the output register
// throughput: one tick per cycle; a new tick is taken whenever the output register
// is empty or being drained in the same cycle
// reset (rst_n low, synchronous): all counters and enables clear, registers return
// to their default settings, output register empties
module print_head_motor_tick_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pmtc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pmtc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  pmtc_in_if.sink                              in_ch,
  pmtc_out_if.source                           out_ch
);
  import pmtc_pkg::*;

  // configuration
  logic [SAMPLE_W-1:0]   paper_threshold_r;
  logic [DEBOUNCE_W-1:0] paper_debounce_r;
  logic [STROBE_W-1:0]   strobe_on_ticks_r;
  logic [INTERVAL_W-1:0] step_interval_r;
  logic [PHASE_W-1:0]    steps_per_burst_r;

  // tick state
  logic [DEBOUNCE_W-1:0] present_count_r, present_count_nxt;
  logic [DEBOUNCE_W-1:0] absent_count_r, absent_count_nxt;
  logic                  paper_flag_r, paper_flag_nxt;
  logic                  heat_master_r, heat_master_nxt;
  logic                  heat_run_r, heat_run_nxt;
  logic [STROBE_W-1:0]   strobe_high_r, strobe_high_nxt;
  logic [STROBE_W-1:0]   strobe_low_r, strobe_low_nxt;
  logic                  motor_master_r, motor_master_nxt;
  logic                  motor_run_r, motor_run_nxt;
  logic [INTERVAL_W-1:0] tick_count_r, tick_count_nxt;
  logic [PHASE_W-1:0]    step_phase_r, step_phase_nxt;
  logic [PHASE_W-1:0]    burst_count_r, burst_count_nxt;

  logic                  out_valid_r;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_xfer;
  logic                  step_fire;
  logic [PHASE_W-1:0]    burst_inc;
  logic [STROBE_W-1:0]   low_inc;
  strobe_state_t         strobe_state;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    heat_master_nxt  = (heat_master_r || in_ch.data.heat_master_set)
                       && !in_ch.data.heat_master_clear;
    heat_run_nxt     = heat_run_r || in_ch.data.heat_run_set;
    motor_master_nxt = (motor_master_r || in_ch.data.motor_master_set)
                       && !in_ch.data.motor_master_clear;
    motor_run_nxt    = motor_run_r || in_ch.data.motor_start;

    // paper debounce, both counters saturate
    if (in_ch.data.paper_sample < paper_threshold_r) begin
      present_count_nxt = (&present_count_r) ? present_count_r
                                             : present_count_r + 1'b1;
      absent_count_nxt  = '0;
    end else begin
      present_count_nxt = '0;
      absent_count_nxt  = (&absent_count_r) ? absent_count_r
                                            : absent_count_r + 1'b1;
    end
    priority if (absent_count_nxt > paper_debounce_r) begin
      paper_flag_nxt = 1'b0;
    end else if (present_count_nxt > paper_debounce_r) begin
      paper_flag_nxt = 1'b1;
    end else begin
      paper_flag_nxt = paper_flag_r;
    end
    if (!paper_flag_nxt) begin
      heat_master_nxt  = 1'b0;
      motor_master_nxt = 1'b0;
    end

    // heat strobe duty counter
    strobe_high_nxt = strobe_high_r;
    strobe_low_nxt  = strobe_low_r;
    low_inc         = strobe_low_r + 1'b1;
    if (heat_master_nxt && heat_run_nxt) begin
      if (strobe_high_r <= strobe_on_ticks_r) begin
        strobe_state = STROBE_ON;
        if (!(&strobe_high_r)) begin
          strobe_high_nxt = strobe_high_r + 1'b1;
        end
      end else begin
        strobe_state   = STROBE_OFF;
        strobe_low_nxt = low_inc;
        if (({1'b0, low_inc} + {1'b0, strobe_on_ticks_r}) > STROBE_FRAME) begin
          strobe_high_nxt = '0;
          strobe_low_nxt  = '0;
        end
      end
    end else begin
      strobe_state = STROBE_RESET;
      heat_run_nxt = 1'b0;
    end

    // motor step burst
    step_fire       = motor_master_nxt && motor_run_nxt
                      && (tick_count_r >= step_interval_r);
    burst_inc       = burst_count_r + 1'b1;
    step_phase_nxt  = step_phase_r;
    burst_count_nxt = burst_count_r;
    tick_count_nxt  = tick_count_r + 1'b1;
    if (step_fire) begin
      tick_count_nxt  = {{(INTERVAL_W-1){1'b0}}, 1'b1};
      step_phase_nxt  = step_phase_r + 1'b1;
      burst_count_nxt = burst_inc;
      if (burst_inc == steps_per_burst_r) begin
        motor_run_nxt   = 1'b0;
        burst_count_nxt = '0;
      end
    end

    out_data_nxt.paper_present  = paper_flag_nxt;
    out_data_nxt.strobe_state   = strobe_state;
    out_data_nxt.step_pulse     = step_fire;
    out_data_nxt.step_phase_out = step_fire ? step_phase_r : '0;
    out_data_nxt.motor_busy     = motor_run_nxt;
    out_data_nxt.heat_enabled   = heat_master_nxt;
    out_data_nxt.motor_enabled  = motor_master_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paper_threshold_r <= PAPER_THRESHOLD_RST;
      paper_debounce_r  <= PAPER_DEBOUNCE_RST;
      strobe_on_ticks_r <= STROBE_ON_RST;
      step_interval_r   <= STEP_INTERVAL_RST;
      steps_per_burst_r <= STEPS_PER_BURST_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PAPER_THRESHOLD: paper_threshold_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_PAPER_DEBOUNCE:  paper_debounce_r  <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_STROBE_ON_TICKS: strobe_on_ticks_r <= cfg_wdata[STROBE_W-1:0];
        CFG_STEP_INTERVAL:   step_interval_r   <= cfg_wdata[INTERVAL_W-1:0];
        CFG_STEPS_PER_BURST: steps_per_burst_r <= cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_count_r <= '0;
      absent_count_r  <= '0;
      paper_flag_r    <= 1'b0;
      heat_master_r   <= 1'b0;
      heat_run_r      <= 1'b0;
      strobe_high_r   <= '0;
      strobe_low_r    <= '0;
      motor_master_r  <= 1'b0;
      motor_run_r     <= 1'b0;
      tick_count_r    <= '0;
      step_phase_r    <= '0;
      burst_count_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        present_count_r <= present_count_nxt;
        absent_count_r  <= absent_count_nxt;
        paper_flag_r    <= paper_flag_nxt;
        heat_master_r   <= heat_master_nxt;
        heat_run_r      <= heat_run_nxt;
        strobe_high_r   <= strobe_high_nxt;
        strobe_low_r    <= strobe_low_nxt;
        motor_master_r  <= motor_master_nxt;
        motor_run_r     <= motor_run_nxt;
        tick_count_r    <= tick_count_nxt;
        step_phase_r    <= step_phase_nxt;
        burst_count_r   <= burst_count_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload holds until the next transfer in
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
